// ----- hdl/i2c_eeprom_master_assert.svh -----
// Assertion macros for the I2C EEPROM master.
`ifndef I2C_EEPROM_MASTER_ASSERT_SVH
`define I2C_EEPROM_MASTER_ASSERT_SVH
// Check that an implication holds at every clock edge out of reset.
`define IEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that an implication holds in the cycle after its antecedent.
`define IEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/iem_pkg.sv -----
// Package: constants and types for the I2C EEPROM master.
package iem_pkg;
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW = $clog2(BUF_DEPTH);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_START1 = 5'd1;
  localparam logic [4:0] ST_TX_DEV = 5'd2;
  localparam logic [4:0] ST_ACK_DEV = 5'd3;
  localparam logic [4:0] ST_TX_AHI = 5'd4;
  localparam logic [4:0] ST_ACK_AHI = 5'd5;
  localparam logic [4:0] ST_TX_ALO = 5'd6;
  localparam logic [4:0] ST_ACK_ALO = 5'd7;
  localparam logic [4:0] ST_START2 = 5'd8;
  localparam logic [4:0] ST_TX_DEVR = 5'd9;
  localparam logic [4:0] ST_ACK_DEVR = 5'd10;
  localparam logic [4:0] ST_RX = 5'd11;
  localparam logic [4:0] ST_MACK = 5'd12;
  localparam logic [4:0] ST_TX_DATA = 5'd13;
  localparam logic [4:0] ST_ACK_DATA = 5'd14;
  localparam logic [4:0] ST_STOP = 5'd15;
  localparam logic [4:0] ST_SETTLE = 5'd16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_PUSH = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [1:0] REG_DEV = 2'd0;
  localparam logic [1:0] REG_AMODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_SETTLE = 2'd3;

  typedef struct packed {
    logic                push;
    logic [BUF_AW-1:0]   waddr;
    logic [7:0]          wdata;
    logic                rd;
    logic [BUF_AW-1:0]   raddr;
  } buf_req_t;
endpackage

// ----- hdl/iem_buffer.sv -----
// Write byte buffer memory, one write and one registered read port.
module iem_buffer (
  input  logic                    clk,
  input  iem_pkg::buf_req_t       req,
  output logic [7:0]              rdata
);
  logic [7:0] mem [iem_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ----- hdl/i2c_eeprom_master.sv -----
// Results leave in the cycle after their item; a full output stage adds none.
// Throughput: one item per cycle while not stalled; each item is one sequencer step.
// A data byte is read from the buffer memory on the item before its load; a byte
// pushed on the load item or the item before it is forwarded around the memory.
// Reset (synchronous, active low) clears control state and restores register
// defaults; the buffer memory holds no reset value and unwritten entries are never loaded.
module i2c_eeprom_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_memory_address,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_read_last,
  output logic        out_busy_res,
  output logic        out_ack_error
);
  localparam int AW = iem_pkg::BUF_AW;

  logic [7:0]  dev_r;
  logic [1:0]  amode_r;
  logic [7:0]  tmo_r;
  logic [19:0] settle_r;

  logic [4:0]  st_r, st_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        rd_r, rd_nxt;
  logic [19:0] wc_r, wc_nxt;
  logic [AW:0] fill_r, fill_nxt;
  logic [AW:0] take_r, take_nxt;
  logic        err_r, err_nxt;
  logic        byp_r;
  logic [7:0]  byp_d_r;

  logic        ov_r;
  logic        o_scl, o_sdl, o_drv, o_rv, o_rl, o_busy, o_err;
  logic [7:0]  o_rb;
  logic        scl, sdl, drv, rv, rl;
  logic [7:0]  rb;

  iem_pkg::buf_req_t req;
  logic [7:0]  rdata;

  logic acc;
  logic [1:0] em;
  logic [7:0] devb;

  assign in_stall = ov_r && out_stall;
  assign acc = in_valid && !in_stall;

  iem_buffer u_buf (.clk(clk), .req(req), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= 8'd160;
      amode_r <= 2'd1;
      tmo_r <= 8'd250;
      settle_r <= 20'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iem_pkg::REG_DEV:     dev_r <= cfg_wdata[7:0];
        iem_pkg::REG_AMODE:   amode_r <= cfg_wdata[1:0];
        iem_pkg::REG_TIMEOUT: tmo_r <= cfg_wdata[7:0];
        default:              settle_r <= cfg_wdata;
      endcase
    end
  end

  // Data bytes are loaded through a read issued one item earlier; the take pointer
  // addresses it. Prefetch read is issued every accepted item.
  always_comb begin
    logic [4:0] st;
    logic [1:0] ph;
    logic       load;
    logic [19:0] wci;
    st_nxt = st_r; ph_nxt = ph_r; bi_nxt = bi_r; sh_nxt = sh_r;
    left_nxt = left_r; addr_nxt = addr_r; rd_nxt = rd_r; wc_nxt = wc_r;
    fill_nxt = fill_r; take_nxt = take_r; err_nxt = err_r;
    scl = 1'b1; sdl = 1'b1; drv = 1'b0; rv = 1'b0; rb = 8'd0; rl = 1'b0;
    load = 1'b0;
    wci = 20'd0;
    req.push = 1'b0;
    req.waddr = fill_r[AW-1:0];
    req.wdata = in_data_byte;
    req.rd = acc;
    req.raddr = take_r[AW-1:0];

    if (in_mode == iem_pkg::MODE_PUSH && !fill_r[AW]) begin
      req.push = acc;
      fill_nxt = fill_r + 1'b1;
    end
    if (in_mode[1] && st_r == iem_pkg::ST_IDLE) begin
      addr_nxt = in_memory_address;
      left_nxt = in_byte_count;
      rd_nxt = in_mode == iem_pkg::MODE_READ;
      err_nxt = 1'b0;
      take_nxt = '0;
      st_nxt = iem_pkg::ST_START1;
      ph_nxt = 2'd0;
      bi_nxt = 3'd0;
    end
    st = st_nxt;
    ph = ph_nxt;
    em = (amode_r == 2'd0) ? 2'd1 : amode_r;
    devb = (em == 2'd3) ? ((dev_r & 8'hFE) + {addr_nxt[14:8], 1'b0}) : (dev_r & 8'hFE);
    scl = (ph == 2'd1) || (ph == 2'd2);

    unique case (st)
      iem_pkg::ST_IDLE: scl = 1'b1;
      iem_pkg::ST_START1, iem_pkg::ST_START2: begin
        drv = 1'b1;
        sdl = ph < 2'd2;
        if (ph == 2'd3) begin
          st_nxt = (st == iem_pkg::ST_START1) ? iem_pkg::ST_TX_DEV : iem_pkg::ST_TX_DEVR;
          sh_nxt = (st == iem_pkg::ST_START1) ? devb : (devb | 8'h01);
          bi_nxt = 3'd0; ph_nxt = 2'd0;
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_TX_DEV, iem_pkg::ST_TX_AHI, iem_pkg::ST_TX_ALO,
      iem_pkg::ST_TX_DEVR, iem_pkg::ST_TX_DATA: begin
        drv = 1'b1;
        sdl = sh_r[3'd7 - bi_r];
        if (ph == 2'd3) begin
          ph_nxt = 2'd0;
          if (bi_r == 3'd7) begin
            st_nxt = st + 5'd1; bi_nxt = 3'd0; wc_nxt = 20'd0;
          end else bi_nxt = bi_r + 3'd1;
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_ACK_DEV, iem_pkg::ST_ACK_AHI, iem_pkg::ST_ACK_ALO,
      iem_pkg::ST_ACK_DEVR, iem_pkg::ST_ACK_DATA: begin
        if (ph == 2'd2) begin
          if (!in_sda_in) ph_nxt = 2'd3;
          else begin
            wci = wc_r + 20'd1;
            wc_nxt = wci;
            if (wci > {12'd0, tmo_r}) begin
              err_nxt = 1'b1; st_nxt = iem_pkg::ST_STOP; ph_nxt = 2'd0; bi_nxt = 3'd0;
            end
          end
        end else if (ph == 2'd3) begin
          ph_nxt = 2'd0; bi_nxt = 3'd0;
          priority case (st)
            iem_pkg::ST_ACK_DEV: begin
              st_nxt = (em == 2'd2) ? iem_pkg::ST_TX_AHI : iem_pkg::ST_TX_ALO;
              sh_nxt = (em == 2'd2) ? addr_r[15:8] : addr_r[7:0];
            end
            iem_pkg::ST_ACK_AHI: begin
              st_nxt = iem_pkg::ST_TX_ALO; sh_nxt = addr_r[7:0];
            end
            iem_pkg::ST_ACK_ALO: begin
              if (rd_r) st_nxt = iem_pkg::ST_START2;
              else load = 1'b1;
            end
            iem_pkg::ST_ACK_DEVR: begin
              st_nxt = iem_pkg::ST_RX; sh_nxt = 8'd0;
            end
            default: begin
              left_nxt = left_r - 8'd1;
              load = 1'b1;
            end
          endcase
          if (load) begin
            if (left_nxt != 8'd0 && take_r < fill_nxt) begin
              st_nxt = iem_pkg::ST_TX_DATA;
              sh_nxt = (take_r == fill_r) ? in_data_byte : (byp_r ? byp_d_r : rdata);
              take_nxt = take_r + 1'b1;
            end else st_nxt = iem_pkg::ST_STOP;
          end
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_RX: begin
        if (ph == 2'd2) sh_nxt = {sh_r[6:0], in_sda_in};
        if (ph == 2'd3) begin
          ph_nxt = 2'd0;
          if (bi_r == 3'd7) begin
            rv = 1'b1; rb = sh_r; rl = left_r == 8'd1;
            left_nxt = left_r - 8'd1;
            st_nxt = iem_pkg::ST_MACK; bi_nxt = 3'd0;
          end else bi_nxt = bi_r + 3'd1;
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_MACK: begin
        drv = 1'b1;
        sdl = left_r == 8'd0;
        if (ph == 2'd3) begin
          ph_nxt = 2'd0; bi_nxt = 3'd0;
          if (left_r == 8'd0) st_nxt = iem_pkg::ST_STOP;
          else begin
            st_nxt = iem_pkg::ST_RX; sh_nxt = 8'd0;
          end
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_STOP: begin
        drv = 1'b1;
        sdl = ph >= 2'd2;
        if (ph >= 2'd2) begin
          ph_nxt = 2'd0; bi_nxt = 3'd0;
          if (!rd_r) begin
            fill_nxt = '0; take_nxt = '0;
          end
          if (!rd_r && !err_r && settle_r != 20'd0) begin
            st_nxt = iem_pkg::ST_SETTLE; wc_nxt = settle_r;
          end else st_nxt = iem_pkg::ST_IDLE;
        end else ph_nxt = ph + 2'd1;
      end
      iem_pkg::ST_SETTLE: begin
        scl = 1'b1;
        wci = (wc_r != 20'd0) ? wc_r - 20'd1 : wc_r;
        wc_nxt = wci;
        if (wci == 20'd0) begin
          st_nxt = iem_pkg::ST_IDLE; ph_nxt = 2'd0; bi_nxt = 3'd0;
        end
      end
      default: begin
        scl = 1'b1; st_nxt = iem_pkg::ST_IDLE; ph_nxt = 2'd0; bi_nxt = 3'd0;
      end
    endcase
    // the prefetch must address the entry the next load will take
    req.raddr = take_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= iem_pkg::ST_IDLE; ph_r <= 2'd0; bi_r <= 3'd0; sh_r <= 8'd0;
      left_r <= 8'd0; addr_r <= 16'd0; rd_r <= 1'b0; wc_r <= 20'd0;
      fill_r <= '0; take_r <= '0; err_r <= 1'b0; ov_r <= 1'b0;
      byp_r <= 1'b0; byp_d_r <= 8'd0;
    end else begin
      if (acc) begin
        st_r <= st_nxt; ph_r <= ph_nxt; bi_r <= bi_nxt; sh_r <= sh_nxt;
        left_r <= left_nxt; addr_r <= addr_nxt; rd_r <= rd_nxt; wc_r <= wc_nxt;
        fill_r <= fill_nxt; take_r <= take_nxt; err_r <= err_nxt;
        byp_r <= req.push && (req.waddr == req.raddr);
        byp_d_r <= in_data_byte;
        ov_r <= 1'b1;
      end else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      o_scl <= scl; o_sdl <= sdl; o_drv <= drv; o_rv <= rv; o_rb <= rb; o_rl <= rl;
      o_busy <= st_nxt != iem_pkg::ST_IDLE; o_err <= err_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_scl_level = o_scl;
  assign out_sda_level = o_sdl;
  assign out_sda_drive = o_drv;
  assign out_read_valid = o_rv;
  assign out_read_byte = o_rb;
  assign out_read_last = o_rl;
  assign out_busy_res = o_busy;
  assign out_ack_error = o_err;

  `include "i2c_eeprom_master_assert.svh"

  `IEM_ASSERT_IMP(a_take_le_fill, 1'b1, take_r <= fill_r)
  `IEM_ASSERT_IMP(a_fill_max, 1'b1, fill_r <= (AW+1)'(iem_pkg::BUF_DEPTH))
  `IEM_ASSERT_NXT(a_hold, ov_r && out_stall, ov_r)
  `IEM_ASSERT_IMP(a_rv_rb, ov_r && !o_rv, o_rb == 8'd0)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the I2C EEPROM master: random bus transactions against a predictor.
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic [1:0]  mode;
    logic [15:0] maddr;
    logic [7:0]  cnt;
    logic [7:0]  data;
    logic        sda;
    bit          hold;
    bit          fast;
  } bus_item_t;

  typedef struct {
    logic       scl;
    logic       sdl;
    logic       drv;
    logic       rv;
    logic [7:0] rb;
    logic       rl;
    logic       busy;
    logic       err;
  } bus_out_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = iem_pkg::REG_DEV;
  logic [19:0] cfg_wdata = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_mode = iem_pkg::MODE_TICK;
  logic [15:0] in_memory_address = 0;
  logic [7:0] in_byte_count = 0, in_data_byte = 0;
  logic in_sda_in = 0;
  logic out_valid, out_stall = 0;
  logic out_scl_level, out_sda_level, out_sda_drive, out_read_valid;
  logic [7:0] out_read_byte;
  logic out_read_last, out_busy_res, out_ack_error;

  i2c_eeprom_master dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  dev_reg, tmo_reg;
  logic [1:0]  amode_reg;
  logic [19:0] settle_reg;
  logic [4:0]  seq;
  logic [1:0]  ph;
  logic [2:0]  bidx;
  logic [7:0]  shreg, left;
  logic [15:0] laddr;
  logic        rdop, errf;
  logic [19:0] wcnt;
  logic [7:0]  wbuf [256];
  int          fill, take;

  bus_item_t pend_q[$];
  bus_out_t  bus_exp_q[$];
  int errors = 0, n_items = 0;
  bit calm = 0, took = 0;
  int gap = 0, ostall_cnt = 0;

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [1:0] eff_amode();
    return amode_reg == 2'd0 ? 2'd1 : amode_reg;
  endfunction

  function automatic logic [7:0] dev_byte();
    logic [7:0] b;
    b = dev_reg & 8'hFE;
    if (eff_amode() == 2'd3) b = b + {laddr[14:8], 1'b0};
    return b;
  endfunction

  function automatic void goto(logic [4:0] s);
    seq = s; ph = 0; bidx = 0;
  endfunction

  function automatic void send(logic [4:0] s, logic [7:0] b);
    goto(s); shreg = b;
  endfunction

  function automatic void next_data();
    if (left != 0 && take < fill) begin
      send(iem_pkg::ST_TX_DATA, wbuf[take]);
      take++;
    end else goto(iem_pkg::ST_STOP);
  endfunction

  function automatic void acked();
    case (seq)
      iem_pkg::ST_ACK_DEV: if (eff_amode() == 2'd2) send(iem_pkg::ST_TX_AHI, laddr[15:8]);
                           else send(iem_pkg::ST_TX_ALO, laddr[7:0]);
      iem_pkg::ST_ACK_AHI: send(iem_pkg::ST_TX_ALO, laddr[7:0]);
      iem_pkg::ST_ACK_ALO: if (rdop) goto(iem_pkg::ST_START2);
                           else next_data();
      iem_pkg::ST_ACK_DEVR: begin
        goto(iem_pkg::ST_RX); shreg = 0;
      end
      default: begin
        left = left - 8'd1; next_data();
      end
    endcase
  endfunction

  function automatic bus_out_t bus_step(bus_item_t it);
    bus_out_t r;
    logic [4:0] s;
    r = '{scl: 1, sdl: 1, drv: 0, rv: 0, rb: 0, rl: 0, busy: 0, err: 0};
    if (it.mode == iem_pkg::MODE_PUSH && fill < 256) begin
      wbuf[fill] = it.data; fill++;
    end
    if ((it.mode == iem_pkg::MODE_WRITE || it.mode == iem_pkg::MODE_READ) &&
        seq == iem_pkg::ST_IDLE) begin
      laddr = it.maddr; left = it.cnt; rdop = it.mode == iem_pkg::MODE_READ;
      errf = 0; take = 0; goto(iem_pkg::ST_START1);
    end
    s = seq;
    r.scl = ph == 1 || ph == 2;
    case (s)
      iem_pkg::ST_IDLE: r.scl = 1;
      iem_pkg::ST_START1, iem_pkg::ST_START2: begin
        r.drv = 1; r.sdl = ph < 2;
        if (ph == 3) begin
          if (s == iem_pkg::ST_START1) send(iem_pkg::ST_TX_DEV, dev_byte());
          else send(iem_pkg::ST_TX_DEVR, dev_byte() | 8'h01);
        end else ph++;
      end
      iem_pkg::ST_TX_DEV, iem_pkg::ST_TX_AHI, iem_pkg::ST_TX_ALO, iem_pkg::ST_TX_DEVR,
      iem_pkg::ST_TX_DATA: begin
        r.drv = 1; r.sdl = shreg[7 - bidx];
        if (ph == 3) begin
          ph = 0;
          if (bidx == 7) begin
            seq = s + 5'd1; bidx = 0; wcnt = 0;
          end else bidx++;
        end else ph++;
      end
      iem_pkg::ST_ACK_DEV, iem_pkg::ST_ACK_AHI, iem_pkg::ST_ACK_ALO, iem_pkg::ST_ACK_DEVR,
      iem_pkg::ST_ACK_DATA: begin
        if (ph == 2) begin
          if (!it.sda) ph = 3;
          else begin
            wcnt++;
            if (wcnt > tmo_reg) begin
              errf = 1; goto(iem_pkg::ST_STOP);
            end
          end
        end else if (ph == 3) acked();
        else ph++;
      end
      iem_pkg::ST_RX: begin
        if (ph == 2) shreg = {shreg[6:0], it.sda};
        if (ph == 3) begin
          ph = 0;
          if (bidx == 7) begin
            r.rv = 1; r.rb = shreg; r.rl = left == 1;
            left = left - 8'd1; goto(iem_pkg::ST_MACK);
          end else bidx++;
        end else ph++;
      end
      iem_pkg::ST_MACK: begin
        r.drv = 1; r.sdl = left == 0;
        if (ph == 3) begin
          if (left == 0) goto(iem_pkg::ST_STOP);
          else begin
            goto(iem_pkg::ST_RX); shreg = 0;
          end
        end else ph++;
      end
      iem_pkg::ST_STOP: begin
        r.drv = 1; r.sdl = ph >= 2;
        if (ph >= 2) begin
          if (!rdop) begin
            fill = 0; take = 0;
          end
          if (!rdop && !errf && settle_reg != 0) begin
            goto(iem_pkg::ST_SETTLE); wcnt = settle_reg;
          end else goto(iem_pkg::ST_IDLE);
        end else ph++;
      end
      iem_pkg::ST_SETTLE: begin
        r.scl = 1;
        if (wcnt != 0) wcnt--;
        if (wcnt == 0) goto(iem_pkg::ST_IDLE);
      end
      default: begin
        r.scl = 1; goto(iem_pkg::ST_IDLE);
      end
    endcase
    r.busy = seq != iem_pkg::ST_IDLE;
    r.err = errf;
    return r;
  endfunction

  // input driver
  always @(negedge clk) begin
    bus_item_t it;
    logic v;
    v = in_valid;
    if (rst_n) begin
      if (in_valid && !took) v = 1;
      else begin
        took = 0; v = 0;
        if (gap > 0) gap--;
        else if (pend_q.size() > 0 &&
                 !(pend_q[0].hold && (bus_exp_q.size() != 0 || in_valid))) begin
          it = pend_q.pop_front();
          in_mode <= it.mode; in_memory_address <= it.maddr; in_byte_count <= it.cnt;
          in_data_byte <= it.data; in_sda_in <= it.sda;
          v = 1;
          gap = (calm || it.fast) ? 0 : $urandom_range(17);
        end
      end
    end
    in_valid <= v;
    out_stall <= ostall_cnt > 0;
    if (ostall_cnt > 0) ostall_cnt--;
  end

  // acceptance and checking
  always @(posedge clk) begin
    bus_item_t it;
    bus_out_t e;
    if (rst_n && in_valid && !in_stall) begin
      it.mode = in_mode; it.maddr = in_memory_address; it.cnt = in_byte_count;
      it.data = in_data_byte; it.sda = in_sda_in;
      bus_exp_q.push_back(bus_step(it));
      took = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      ostall_cnt = calm ? 0 : $urandom_range(17);
      if (bus_exp_q.size() == 0) begin
        $display("unexpected transfer at %0t", $realtime);
        errors++;
      end else begin
        e = bus_exp_q.pop_front();
        if (out_scl_level !== e.scl) report("scl_level", out_scl_level, e.scl);
        if (out_sda_level !== e.sdl) report("sda_level", out_sda_level, e.sdl);
        if (out_sda_drive !== e.drv) report("sda_drive", out_sda_drive, e.drv);
        if (out_read_valid !== e.rv) report("read_valid", out_read_valid, e.rv);
        if (out_read_byte !== e.rb) report("read_byte", out_read_byte, e.rb);
        if (out_read_last !== e.rl) report("read_last", out_read_last, e.rl);
        if (out_busy_res !== e.busy) report("busy_res", out_busy_res, e.busy);
        if (out_ack_error !== e.err) report("ack_error", out_ack_error, e.err);
      end
    end
  end

  task automatic add_item(logic [1:0] m, logic [15:0] a, logic [7:0] c, logic [7:0] d,
                          logic s, bit h, bit f);
    pend_q.push_back('{mode: m, maddr: a, cnt: c, data: d, sda: s, hold: h, fast: f});
    n_items++;
  endtask

  task automatic wait_empty();
    while (pend_q.size() != 0 || in_valid || bus_exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    wait_empty();
    while (seq != iem_pkg::ST_IDLE) begin
      repeat (64) add_item(iem_pkg::MODE_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                           0, 0, 1);
      wait_empty();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      iem_pkg::REG_DEV: dev_reg = val[7:0];
      iem_pkg::REG_AMODE: amode_reg = val[1:0];
      iem_pkg::REG_TIMEOUT: tmo_reg = val[7:0];
      default: settle_reg = val;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one transaction: optional pushes, a start, then enough items, mostly ticks, to finish it
  task automatic transaction(bit rd, logic [7:0] cnt, int npush, int pone, bit h);
    int nb, nt;
    logic [1:0] m;
    repeat (npush) add_item(iem_pkg::MODE_PUSH, 16'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom), 0, 0);
    add_item(rd ? iem_pkg::MODE_READ : iem_pkg::MODE_WRITE, 16'($urandom), cnt,
             8'($urandom), 1'($urandom), h, 0);
    nb = rd ? cnt : (cnt < npush ? cnt : npush);
    nt = 36 * (nb + (rd ? 3 : 2) + (eff_amode() == 2'd2 ? 1 : 0)) + 16;
    if (!rd) nt += (settle_reg < 20'd32) ? int'(settle_reg) : 32;
    repeat (nt) begin
      m = ($urandom_range(99) < 4) ? 2'($urandom_range(3, 1)) : iem_pkg::MODE_TICK;
      add_item(m, 16'($urandom), 8'($urandom_range(255, 1)), 8'($urandom),
               $urandom_range(99) < pone, 0, 0);
    end
  endtask

  initial begin
    int target, pone;
    logic [19:0] settle_set [5];
    settle_set = '{20'd10000, 20'd0, 20'd1, 20'd25, 20'd1048575};
    dev_reg = 8'hA0; amode_reg = 2'd1; tmo_reg = 8'd250; settle_reg = 20'd10000;
    seq = iem_pkg::ST_IDLE; ph = 0; bidx = 0; shreg = 0; left = 0; laddr = 0;
    rdop = 0; errf = 0; wcnt = 0; fill = 0; take = 0;
    foreach (wbuf[i]) wbuf[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // short settle keeps the run brief; other registers stay at reset values
    write_reg(iem_pkg::REG_SETTLE, 20'd3);

    // directed: extremes of data, write then read
    add_item(iem_pkg::MODE_PUSH, 16'h0, 8'd1, 8'h00, 0, 0, 0);
    add_item(iem_pkg::MODE_PUSH, 16'hFFFF, 8'd255, 8'hFF, 1, 0, 0);
    add_item(iem_pkg::MODE_PUSH, 16'h0, 8'd1, 8'hA5, 0, 0, 0);
    transaction(0, 8'd255, 0, 0, 0);
    quiesce();
    transaction(1, 8'd1, 1, 0, 1);
    quiesce();

    for (int p = 1; p < 5; p++) begin
      write_reg(iem_pkg::REG_DEV, p == 1 ? 20'h00 : p == 2 ? 20'hFF :
                20'($urandom_range(255)));
      write_reg(iem_pkg::REG_AMODE, p == 1 ? 20'd0 : 20'(p % 4));
      write_reg(iem_pkg::REG_TIMEOUT, p == 2 ? 20'd0 : p == 3 ? 20'd255 :
                20'($urandom_range(255)));
      write_reg(iem_pkg::REG_SETTLE, settle_set[p]);
      if (p == 2) begin
        // missing acknowledge held past the timeout
        add_item(iem_pkg::MODE_PUSH, 0, 1, 8'h3C, 0, 0, 0);
        add_item(iem_pkg::MODE_WRITE, 16'h1234, 8'd1, 0, 0, 0, 0);
        repeat (64) add_item(iem_pkg::MODE_TICK, 0, 1, 0, 1, 0, 1);
        // buffer full: more pushes than it holds
        repeat (258) add_item(iem_pkg::MODE_PUSH, 16'($urandom), 1, 8'($urandom), 0, 0, 1);
        transaction(0, 8'd3, 0, 0, 0);
        quiesce();
      end
      target = n_items + 40;
      while (n_items < target) begin
        calm = $urandom_range(3) == 0;
        pone = $urandom_range(2) == 0 ? 0 : $urandom_range(1) ? 5 : 50;
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(6, 1))
            add_item(2'($urandom), 16'($urandom), 8'($urandom_range(255, 1)), 8'($urandom),
                     1'($urandom), 0, 0);
        else if (p == 4 || $urandom_range(1))
          transaction(1, 8'($urandom_range(3, 1)), $urandom_range(3), pone,
                      $urandom_range(9) == 0);
        else
          transaction(0, 8'($urandom_range(255, 1)), $urandom_range(5), pone,
                      $urandom_range(9) == 0);
        if (p == 4) begin
          // long settle value: never let a write complete here
          foreach (pend_q[i])
            if (pend_q[i].mode == iem_pkg::MODE_WRITE) pend_q[i].mode = iem_pkg::MODE_READ;
        end
        wait_empty();
      end
      calm = 0;
      quiesce();
    end

    wait_empty();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("i2c_eeprom_master verification clean");
    else $display("i2c_eeprom_master verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("i2c_eeprom_master verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/iem_pkg.sv
hdl/iem_buffer.sv
hdl/i2c_eeprom_master.sv
verif/tb.sv
